// ===== rtl/console_line_editor_unit_macros.svh =====
// ============================================================================
// Assertion macros for the console line editor
// Shared property templates used by the RTL assertion sections.
// ============================================================================
`ifndef CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH
`define CONSOLE_LINE_EDITOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CLE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CLE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// ============================================================================
// Console line editor package
// Key codes and control state type shared by the line editor files.
// ============================================================================
package cle_pkg;

	// Editing keys
	localparam logic [7:0] KEY_NUL  = 8'h00;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_NL   = 8'h0A;
	localparam logic [7:0] KEY_KILL = 8'h15;

	// Control state: collect keys, or read a finished line out of the store
	typedef enum logic {
		S_IDLE  = 1'b0,
		S_DRAIN = 1'b1
	} cle_state_t;

endpackage

// ===== rtl/cle_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port, one read port with enable; read data is registered.
// ============================================================================
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/console_line_editor_unit.sv =====
// ============================================================================
// Console line editor
// Keyboard line discipline with cooked editing and raw pass-through.
// ============================================================================
// A key item is written into the line store at the fill position when it is
// taken. When a key completes a line (newline, end of file, a raw byte with
// nothing waiting, a flush, or a full store), the input stalls while the line
// is read back through the store's single read port, one byte per cycle while
// the output does not stall. Two register stages (read data, output
// register) sit between the store and the output port, so the next key is
// taken while the tail of a line is still being delivered.
// Configuration (raw_mode) is taken at any time through cfg_valid/cfg_ready.
// ============================================================================
`include "console_line_editor_unit_macros.svh"

module console_line_editor_unit #(
	parameter int LINE_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// key input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       more_waiting,
	// line output
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       empty_line,
	output logic       line_end,
	// configuration
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	localparam int AW = $clog2(LINE_LEN);
	localparam int CW = $clog2(LINE_LEN + 1);

	cle_pkg::cle_state_t state_q, state_d;

	logic          raw_mode_q;
	logic [CW-1:0] fill_q, fill_d;
	logic [CW-1:0] len_q, len_d;
	logic [AW-1:0] rd_idx_q, rd_idx_d;

	logic          in_acc;
	logic          store;
	logic          send;
	logic [CW-1:0] fill_new;

	logic          issue;
	logic          issue_last;
	logic          rd_en;
	logic [7:0]    rd_data;

	logic          vld_s1, empty_s1, last_s1;
	logic          move_s1;

	logic          out_valid_q, out_empty_q, out_end_q;
	logic [7:0]    out_byte_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			raw_mode_q <= cfg_data;
		end
	end

	// Decode the key: what to store, new fill, whether the line goes out
	always_comb begin
		store    = 1'b0;
		send     = 1'b0;
		fill_new = fill_q;
		if (in_byte == cle_pkg::KEY_NUL) begin
			send = (fill_q != '0) && !more_waiting;
		end else if (raw_mode_q) begin
			store = 1'b1;
			send  = !more_waiting;
		end else begin
			case (in_byte)
				cle_pkg::KEY_BS: begin
					if (fill_q != '0) begin
						fill_new = fill_q - CW'(1);
					end
				end
				cle_pkg::KEY_KILL: begin
					fill_new = '0;
				end
				cle_pkg::KEY_EOF: begin
					send = 1'b1;
				end
				cle_pkg::KEY_NL: begin
					store = 1'b1;
					send  = 1'b1;
				end
				default: begin
					store = 1'b1;
				end
			endcase
		end
		if (store) begin
			fill_new = fill_q + CW'(1);
		end
		if (fill_new == CW'(LINE_LEN)) begin
			send = 1'b1;
		end
	end

	// Read-out stage handoff
	assign move_s1    = vld_s1 && (!out_valid_q || !out_stall);
	assign issue_last = (len_q == '0) || (CW'(rd_idx_q) == len_q - CW'(1));

	// Next state and control
	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		len_d    = len_q;
		rd_idx_d = rd_idx_q;
		in_stall = 1'b1;
		in_acc   = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			cle_pkg::S_IDLE: begin
				in_stall = 1'b0;
				in_acc   = in_valid;
				if (in_valid) begin
					if (send) begin
						len_d    = fill_new;
						fill_d   = '0;
						rd_idx_d = '0;
						state_d  = cle_pkg::S_DRAIN;
					end else begin
						fill_d = fill_new;
					end
				end
			end
			cle_pkg::S_DRAIN: begin
				issue = !vld_s1 || move_s1;
				if (issue) begin
					rd_idx_d = rd_idx_q + AW'(1);
					if (issue_last) begin
						state_d = cle_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = cle_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cle_pkg::S_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			len_q    <= len_d;
			rd_idx_q <= rd_idx_d;
		end
	end

	// Line store
	assign rd_en = issue && (len_q != '0);

	cle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_LEN)
	) u_line_store (
		.clk     (clk),
		.wr_en   (in_acc && store),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (in_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// Read-data stage: tracks the item held in the store's read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			empty_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (issue) begin
			vld_s1   <= 1'b1;
			empty_s1 <= (len_q == '0);
			last_s1  <= issue_last;
		end else if (move_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_byte_q  <= empty_s1 ? 8'h00 : rd_data;
			out_empty_q <= empty_s1;
			out_end_q   <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign empty_line = out_empty_q;
	assign line_end   = out_end_q;

	// Assertions
	`CLE_ASSERT_IMP(a_fill_below_len, clk, arst_n, state_q == cle_pkg::S_IDLE, fill_q < CW'(LINE_LEN), "full line left in store while collecting")
	`CLE_ASSERT_NXT(a_s1_holds, clk, arst_n, vld_s1 && !move_s1, vld_s1 && $stable(rd_data), "read data lost while output stalled")
	`CLE_ASSERT_NXT(a_last_ends_drain, clk, arst_n, issue && issue_last, state_q == cle_pkg::S_IDLE && last_s1, "read-out did not finish on last byte")

endmodule

// ===== tb/sv/tb_console_line_editor_unit.sv =====
// ============================================================================
// Console line editor testbench
// Sends cooked and raw key streams through the line editor. Each accepted
// key goes into a behavioral line model in the scoreboard, which queues the
// bytes of every line it delivers. Every delivered output item is checked
// against the oldest queued byte, field by field. Bursty input, a changing
// output stall pattern and raw_mode changes between phases.
// ============================================================================
module tb_console_line_editor_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_LEN      = 64;
	localparam int HALF_PERIOD   = 5;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 100;

	// One byte of a delivered line
	typedef struct packed {
		logic [7:0] data;
		logic       empty;
		logic       tail;
	} line_beat_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PERIODIC
	} rx_pattern_t;

	// Line discipline model and queue of bytes still to be delivered
	class line_board;
		logic [7:0]  store [LINE_LEN];
		int unsigned fill;
		bit          raw;
		line_beat_t  due [$];
		int          errors;

		function new();
			fill   = 0;
			raw    = 1'b0;
			errors = 0;
		endfunction

		function void set_raw(bit m);
			raw = m;
		endfunction

		function void put(logic [7:0] b);
			if (fill < LINE_LEN) begin
				store[fill] = b;
				fill++;
			end
		endfunction

		// Apply one accepted key and queue whatever line it releases
		function void accept_key(logic [7:0] b, logic more);
			bit         send;
			line_beat_t beat;
			send = 1'b0;
			if (b == cle_pkg::KEY_NUL) begin
				if (fill > 0)
					send = !more;
			end else if (raw) begin
				put(b);
				send = !more;
			end else begin
				case (b)
					cle_pkg::KEY_BS: begin
						if (fill > 0)
							fill--;
					end
					cle_pkg::KEY_KILL: fill = 0;
					cle_pkg::KEY_EOF:  send = 1'b1;
					cle_pkg::KEY_NL: begin
						put(b);
						send = 1'b1;
					end
					default:  put(b);
				endcase
			end
			if (send || fill >= LINE_LEN) begin
				if (fill == 0) begin
					beat.data  = cle_pkg::KEY_NUL;
					beat.empty = 1'b1;
					beat.tail  = 1'b1;
					due.push_back(beat);
				end else begin
					for (int k = 0; k < fill; k++) begin
						beat.data  = store[k];
						beat.empty = 1'b0;
						beat.tail  = (k + 1 == fill);
						due.push_back(beat);
					end
					fill = 0;
				end
			end
		endfunction

		task report(string msg);
			if (errors < MAX_REPORTS)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one delivered output item with the oldest queued byte
		task check_output(logic [7:0] data, logic empty, logic tail);
			line_beat_t want;
			if (due.size() == 0) begin
				report($sformatf("output item with nothing queued: byte %02h empty %0b end %0b",
					data, empty, tail));
				return;
			end
			want = due.pop_front();
			if (data !== want.data)
				report($sformatf("out_byte %02h, want %02h", data, want.data));
			if (empty !== want.empty)
				report($sformatf("empty_line %0b, want %0b", empty, want.empty));
			if (tail !== want.tail)
				report($sformatf("line_end %0b, want %0b", tail, want.tail));
		endtask
	endclass

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte      = 8'h00;
	logic       more_waiting = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] out_byte;
	logic       empty_line;
	logic       line_end;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic       cfg_data     = 1'b0;

	line_board   board;
	int          burst_left  = 0;
	int          keys_sent   = 0;
	int          cycle_count = 0;
	rx_pattern_t rx_pattern  = RX_FREE;

	console_line_editor_unit #(
		.LINE_LEN(LINE_LEN)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.more_waiting(more_waiting),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.empty_line  (empty_line),
		.line_end    (line_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Check delivered items, vary the output stall, watch the cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			if (arst_n && out_valid && !out_stall)
				board.check_output(out_byte, empty_line, line_end);
			if (cycle_count % 48 == 0)
				rx_pattern = rx_pattern_t'($urandom_range(0, 2));
			case (rx_pattern)
				RX_FREE:     out_stall <= 1'b0;
				RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
				RX_PERIODIC: out_stall <= (cycle_count % 7 < 3);
				default:     out_stall <= 1'b0;
			endcase
		end
	end

	// Offer one key item, with a random gap between bursts, and hold it until taken
	task automatic send_key(input logic [7:0] b, input logic more);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid     <= 1'b1;
		in_byte      <= b;
		more_waiting <= more;
		do @(posedge clk); while (in_stall);
		board.accept_key(b, more);
		burst_left--;
		keys_sent++;
	endtask

	// Drop valid and wait until every queued byte has come out
	task automatic settle();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (board.due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write raw_mode while the block is idle
	task automatic write_mode(input bit m);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_raw(m);
	endtask

	// Send one line shaped for the current mode; long lines fill the store
	task automatic random_line(input bit long_line);
		int         len;
		int         pick;
		bit         tail_flush;
		logic [7:0] b;
		if (long_line)
			len = LINE_LEN + $urandom_range(0, 3);
		else if ($urandom_range(0, 7) == 0)
			len = $urandom_range(13, 40);
		else
			len = $urandom_range(board.raw ? 1 : 0, 12);
		if (board.raw) begin
			// Raw: every byte but the last has more waiting; with a tail flush the last one does too and a flush key follows
			tail_flush = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < len; i++) begin
				send_key(8'($urandom_range(1, 255)), (i + 1 < len) || tail_flush);
			end
			if (tail_flush)
				send_key(cle_pkg::KEY_NUL, 1'b0);
		end else begin
			// Cooked: mostly plain bytes with some editing, then a terminator
			for (int i = 0; i < len; i++) begin
				pick = long_line ? 0 : $urandom_range(0, 19);
				b = 8'($urandom_range(1, 255));
				if (b == cle_pkg::KEY_BS || b == cle_pkg::KEY_KILL ||
					b == cle_pkg::KEY_EOF || b == cle_pkg::KEY_NL)
					b = 8'h5A;
				if (pick == 16 || pick == 17)
					b = cle_pkg::KEY_BS;
				else if (pick == 18)
					b = cle_pkg::KEY_KILL;
				else if (pick == 19)
					b = cle_pkg::KEY_NUL;
				send_key(b, 1'($urandom_range(0, 1)));
			end
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_key(cle_pkg::KEY_NL, 1'($urandom_range(0, 1)));
			else if (pick < 9)
				send_key(cle_pkg::KEY_EOF, 1'($urandom_range(0, 1)));
			else
				send_key(cle_pkg::KEY_NUL, 1'b0);
		end
	endtask

	// Mix well-formed lines with single random keys until the budget is spent, after an optional full line
	task automatic random_phase(input int budget, input bit with_full);
		int start;
		start = keys_sent;
		if (with_full)
			random_line(1'b1);
		while (keys_sent - start < budget) begin
			if ($urandom_range(0, 7) == 0)
				send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			else
				random_line(1'b0);
		end
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Cooked editing keys
		write_mode(1'b0);
		send_key(8'h68, 1'b1);
		send_key(8'hFF, 1'b0);
		send_key(cle_pkg::KEY_BS, 1'b0);
		send_key(cle_pkg::KEY_NL, 1'b0);
		send_key(cle_pkg::KEY_BS, 1'b0);    // backspace on an empty line
		send_key(cle_pkg::KEY_EOF, 1'b0);   // end of file on an empty line
		send_key(8'h61, 1'b1);
		send_key(8'h62, 1'b1);
		send_key(cle_pkg::KEY_KILL, 1'b0);
		send_key(cle_pkg::KEY_NL, 1'b1);
		send_key(8'h78, 1'b1);
		send_key(cle_pkg::KEY_NUL, 1'b1);   // flush held off while more is waiting
		send_key(cle_pkg::KEY_NUL, 1'b0);
		send_key(cle_pkg::KEY_NUL, 1'b0);   // flush key on an empty line is ignored
		send_key(8'h01, 1'b0);
		send_key(8'h80, 1'b1);
		send_key(cle_pkg::KEY_EOF, 1'b1);

		// Raw mode stores editing keys as data
		write_mode(1'b1);
		send_key(cle_pkg::KEY_BS, 1'b1);
		send_key(cle_pkg::KEY_KILL, 1'b1);
		send_key(cle_pkg::KEY_EOF, 1'b1);
		send_key(cle_pkg::KEY_NL, 1'b1);
		send_key(8'hFF, 1'b0);
		send_key(cle_pkg::KEY_NUL, 1'b0);
		send_key(8'h7A, 1'b0);

		random_phase(64, 1'b1);
		write_mode(1'b0);
		random_phase(20, 1'b0);
		write_mode(1'b1);
		random_phase(8, 1'b0);
		write_mode(1'b0);
		random_phase(8, 1'b0);
		settle();

		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
